// ===== hw/rtl/lsch_pkg.sv =====
package lsch_pkg;

    // Field widths fixed by the word format
    localparam int unsigned TICKET_W = 8;
    localparam int unsigned SLICE_W  = 8;
    localparam int unsigned RAND_W   = 16;
    localparam int unsigned SLOT_W   = 2;

    // Item kinds carried on the mode field
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_SCAN,
        S_GRANT,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/lsch_mod.sv =====
// Restoring remainder unit: one quotient bit per cycle.
module lsch_mod #(
    parameter int unsigned DW = 16,
    parameter int unsigned VW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [VW-1:0] o_rem
);

    localparam int unsigned CW = $clog2(DW + 1);

    logic [DW-1:0] r_dvd;
    logic [VW-1:0] r_div;
    logic [VW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   trial;
    logic          fits;

    // One trial subtract per step
    always_comb begin
        trial = {r_rem, r_dvd[DW-1]};
        fits  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            if (fits) begin
                r_rem <= VW'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[VW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/lottery_scheduler.sv =====
// Channel   | Valid    | Ready    | Payload
// ----------+----------+----------+-------------------------------------------------
// in word   | i_valid  | o_ready  | i_mode i_slot i_ticket_count i_slice_count
//           |          |          | i_random_value
// out word  | o_valid  | i_ready  | o_winner o_granted o_winner_finished o_all_done
//           |          |          | o_empty_error
//
// A load passes through S_LOAD and S_DONE. A draw runs the remainder unit
// (one bit of random_value per cycle), scans the slots in order up to the
// winner and passes through S_GRANT and S_DONE; a draw on an empty total
// goes straight to S_DONE. One word is in work at a time.
// Reset (i_rst_n low, synchronous) clears all slots and the total.
// A waiting result holds only the completion of the next word, not its accept.
module lottery_scheduler #(
    parameter int unsigned JOB_SLOTS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic [lsch_pkg::SLOT_W-1:0]  i_slot,
    input  logic [lsch_pkg::TICKET_W-1:0] i_ticket_count,
    input  logic [lsch_pkg::SLICE_W-1:0] i_slice_count,
    input  logic [lsch_pkg::RAND_W-1:0]  i_random_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lsch_pkg::SLOT_W-1:0]  o_winner,
    output logic                         o_granted,
    output logic                         o_winner_finished,
    output logic                         o_all_done,
    output logic                         o_empty_error
);

    localparam int unsigned SW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam int unsigned TW = $clog2(JOB_SLOTS * 255 + 1);
    localparam int unsigned TKW = lsch_pkg::TICKET_W;
    localparam int unsigned SLW = lsch_pkg::SLICE_W;

    lsch_pkg::t_state r_state, n_state;

    // Slot storage and running total
    logic [TKW-1:0] r_tix [JOB_SLOTS];
    logic [SLW-1:0] r_rem [JOB_SLOTS];
    logic [TW-1:0]  r_total;

    // Captured word
    logic           r_in_range;
    logic [SW-1:0]  r_slot;
    logic [TKW-1:0] r_new_tix;
    logic [SLW-1:0] r_new_slc;

    // Draw working registers
    logic [TW-1:0]  r_drawn;
    logic [TW-1:0]  r_run;
    logic [SW-1:0]  r_idx;

    // Pending result
    logic [SW-1:0]  r_res_winner;
    logic           r_res_granted;
    logic           r_res_fin;
    logic           r_res_err;

    logic           accept;
    logic           xfer;
    logic           div_start;
    logic           div_done;
    logic [TW-1:0]  div_rem;

    logic [TKW-1:0] cur_tix;
    logic [SLW-1:0] cur_rem;
    logic           cur_active;
    logic [TW-1:0]  run_next;
    logic           hit;
    logic           last_idx;

    logic [TW-1:0]  old_contrib;
    logic [TW-1:0]  new_contrib;
    logic [SLW-1:0] win_rem_next;

    // Handshake and control
    always_comb begin
        o_ready   = (r_state == lsch_pkg::S_IDLE);
        accept    = i_valid && o_ready;
        xfer      = (r_state == lsch_pkg::S_DONE) && (!o_valid || i_ready);
        div_start = accept && (i_mode == lsch_pkg::MODE_DRAW) && (r_total != '0);
    end

    lsch_mod #(
        .DW (lsch_pkg::RAND_W),
        .VW (TW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_random_value),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Scan step: one slot per cycle
    always_comb begin
        cur_tix    = r_tix[r_idx];
        cur_rem    = r_rem[r_idx];
        cur_active = (cur_rem != '0);
        run_next   = cur_active ? (r_run + TW'(cur_tix)) : r_run;
        hit        = cur_active && (r_drawn < run_next);
        last_idx   = (r_idx == SW'(JOB_SLOTS - 1));
    end

    // Load: swap the slot's old share of the total for the new one
    always_comb begin
        old_contrib  = (r_rem[r_slot] != '0) ? TW'(r_tix[r_slot]) : '0;
        new_contrib  = (r_new_slc != '0) ? TW'(r_new_tix) : '0;
        win_rem_next = r_rem[r_res_winner] - 1'b1;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsch_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_mode == lsch_pkg::MODE_LOAD) begin
                        n_state = lsch_pkg::S_LOAD;
                    end else if (r_total == '0) begin
                        n_state = lsch_pkg::S_DONE;
                    end else begin
                        n_state = lsch_pkg::S_DIV;
                    end
                end
            end
            lsch_pkg::S_LOAD:  n_state = lsch_pkg::S_DONE;
            lsch_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = lsch_pkg::S_SCAN;
                end
            end
            lsch_pkg::S_SCAN: begin
                if (hit) begin
                    n_state = lsch_pkg::S_GRANT;
                end else if (last_idx) begin
                    n_state = lsch_pkg::S_DONE;
                end
            end
            lsch_pkg::S_GRANT: n_state = lsch_pkg::S_DONE;
            lsch_pkg::S_DONE: begin
                if (xfer) begin
                    n_state = lsch_pkg::S_IDLE;
                end
            end
            default: n_state = lsch_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsch_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Slot state and total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < JOB_SLOTS; i++) begin
                r_tix[i] <= '0;
                r_rem[i] <= '0;
            end
            r_total <= '0;
        end else if (r_state == lsch_pkg::S_LOAD) begin
            if (r_in_range) begin
                r_tix[r_slot] <= r_new_tix;
                r_rem[r_slot] <= r_new_slc;
                r_total       <= r_total - old_contrib + new_contrib;
            end
        end else if (r_state == lsch_pkg::S_GRANT) begin
            r_rem[r_res_winner] <= win_rem_next;
            if (win_rem_next == '0) begin
                r_total <= r_total - TW'(r_tix[r_res_winner]);
            end
        end
    end

    // Word capture, draw working set and pending result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_range    <= (32'(i_slot) < JOB_SLOTS);
            r_slot        <= SW'(i_slot);
            r_new_tix     <= i_ticket_count;
            r_new_slc     <= i_slice_count;
            r_res_winner  <= '0;
            r_res_granted <= 1'b0;
            r_res_fin     <= 1'b0;
            r_res_err     <= (i_mode == lsch_pkg::MODE_DRAW) && (r_total == '0);
        end
        if (div_done) begin
            r_drawn <= div_rem;
            r_run   <= '0;
            r_idx   <= '0;
        end else if (r_state == lsch_pkg::S_SCAN) begin
            r_run <= run_next;
            if (hit) begin
                r_res_winner  <= r_idx;
                r_res_granted <= 1'b1;
            end else if (!last_idx) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (r_state == lsch_pkg::S_GRANT) begin
            r_res_fin <= (win_rem_next == '0);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (xfer) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            o_winner          <= lsch_pkg::SLOT_W'(r_res_winner);
            o_granted         <= r_res_granted;
            o_winner_finished <= r_res_fin;
            o_all_done        <= (r_total == '0);
            o_empty_error     <= r_res_err;
        end
    end

endmodule
